FILE: rtl/core/btpc_pkg.sv
`timescale 1ns / 1ps
package btpc_pkg;

  // Multiplier operand and product widths
  localparam int MUL_W  = 25;
  localparam int PROD_W = 2 * MUL_W;
  // Width of the stored offset and sensitivity terms
  localparam int TERM_W = 48;

  // Temperature thresholds in centidegrees
  localparam int TEMP_NOMINAL = 2000;
  localparam int TEMP_COLD    = -1500;

  // Configuration register indexes
  localparam logic [2:0] CFG_C1      = 3'd0;
  localparam logic [2:0] CFG_C2      = 3'd1;
  localparam logic [2:0] CFG_C3      = 3'd2;
  localparam logic [2:0] CFG_C4      = 3'd3;
  localparam logic [2:0] CFG_C5      = 3'd4;
  localparam logic [2:0] CFG_C6      = 3'd5;
  localparam logic [2:0] CFG_VARIANT = 3'd6;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T_DT,
    ST_T_MC6,
    ST_T_MC4,
    ST_T_MC3,
    ST_T_MDT,
    ST_T_MF,
    ST_T_MG,
    ST_T_CF,
    ST_T_CG,
    ST_P_LO,
    ST_P_HI,
    ST_P_SUM,
    ST_P_FIN,
    ST_DONE
  } state_t;

  // Calibration words
  typedef struct packed {
    logic [15:0] c1;
    logic [15:0] c2;
    logic [15:0] c3;
    logic [15:0] c4;
    logic [15:0] c5;
    logic [15:0] c6;
    logic        variant;
  } btpc_cal_t;

  // One finished result
  typedef struct packed {
    logic               is_pressure;
    logic signed [31:0] temperature_centideg;
    logic signed [31:0] pressure_pa;
  } btpc_res_t;

endpackage

FILE: rtl/core/btpc_mul.sv
`timescale 1ns / 1ps
module btpc_mul (
  input  logic                             clk,
  input  logic signed [btpc_pkg::MUL_W-1:0]  a,
  input  logic signed [btpc_pkg::MUL_W-1:0]  b,
  output logic signed [btpc_pkg::PROD_W-1:0] p
);
  import btpc_pkg::*;

  // Register the signed product
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

FILE: rtl/core/btpc_engine.sv
`timescale 1ns / 1ps
module btpc_engine (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [23:0]           raw,
  input  logic                  is_temp,
  input  btpc_pkg::btpc_cal_t   cal,
  input  logic                  res_ready,
  output logic                  busy,
  output logic                  res_valid,
  output btpc_pkg::btpc_res_t   res
);
  import btpc_pkg::*;

  state_t state, state_next;

  logic [23:0]               raw_q;
  logic                      is_pres;
  logic signed [MUL_W-1:0]   dt;
  logic signed [17:0]        x;
  logic signed [18:0]        y;
  logic [17:0]               t2;
  logic [35:0]               f;
  logic [35:0]               g;
  logic signed [TERM_W-1:0]  off;
  logic signed [TERM_W-1:0]  sens;
  logic signed [63:0]        acc;
  logic signed [31:0]        pres;

  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]  prod;

  logic [TERM_W-1:0]         f48;
  logic [TERM_W-1:0]         g48;
  logic [TERM_W-1:0]         off2f;
  logic [TERM_W-1:0]         sens2f;
  logic [TERM_W-1:0]         off2g;
  logic [TERM_W-1:0]         sens2g;
  logic [TERM_W-1:0]         off_base;
  logic [TERM_W-1:0]         sens_base;
  logic signed [63:0]        p_diff;
  logic signed [31:0]        temp_res;

  btpc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Temperature offset from the cold threshold
  assign y = {x[17], x} + 19'(TEMP_NOMINAL - TEMP_COLD);

  // Constant scalings of the squared terms
  assign f48 = TERM_W'(f);
  assign g48 = TERM_W'(g);
  assign off2f  = cal.variant ? (((f48 << 6) - (f48 << 2) + f48) >> 4)
                              : (((f48 << 2) + f48) >> 1);
  assign sens2f = cal.variant ? (f48 << 1) : (((f48 << 2) + f48) >> 2);
  assign off2g  = cal.variant ? ((g48 << 4) - g48) : ((g48 << 3) - g48);
  assign sens2g = cal.variant ? (g48 << 3)
                              : (((g48 << 3) + (g48 << 1) + g48) >> 1);

  // First-order terms from the product in flight
  assign off_base  = cal.variant ?
      (TERM_W'({cal.c2, 17'b0}) + TERM_W'(prod >>> 6)) :
      (TERM_W'({cal.c2, 16'b0}) + TERM_W'(prod >>> 7));
  assign sens_base = cal.variant ?
      (TERM_W'({cal.c1, 16'b0}) + TERM_W'(prod >>> 7)) :
      (TERM_W'({cal.c1, 15'b0}) + TERM_W'(prod >>> 8));

  // Pressure before the final shift
  assign p_diff = (acc >>> 21) - 64'(off);

  // Final temperature with the second-order step removed
  assign temp_res = 32'(TEMP_NOMINAL) + {{14{x[17]}}, x} - {14'b0, t2};

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance the sequencer and steer the multiplier
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = is_temp ? ST_T_DT : ST_P_LO;
      end
      ST_T_DT:  state_next = ST_T_MC6;
      ST_T_MC6: begin
        mul_a      = dt;
        mul_b      = {9'b0, cal.c6};
        state_next = ST_T_MC4;
      end
      ST_T_MC4: begin
        mul_a      = {9'b0, cal.c4};
        mul_b      = dt;
        state_next = ST_T_MC3;
      end
      ST_T_MC3: begin
        mul_a      = {9'b0, cal.c3};
        mul_b      = dt;
        state_next = ST_T_MDT;
      end
      ST_T_MDT: begin
        mul_a      = dt;
        mul_b      = dt;
        state_next = x[17] ? ST_T_MF : ST_DONE;
      end
      ST_T_MF: begin
        mul_a      = {{7{x[17]}}, x};
        mul_b      = {{7{x[17]}}, x};
        state_next = ST_T_MG;
      end
      ST_T_MG: begin
        mul_a      = {{6{y[18]}}, y};
        mul_b      = {{6{y[18]}}, y};
        state_next = ST_T_CF;
      end
      ST_T_CF:  state_next = ST_T_CG;
      ST_T_CG:  state_next = ST_DONE;
      ST_P_LO: begin
        mul_a      = {1'b0, raw_q};
        mul_b      = {1'b0, sens[23:0]};
        state_next = ST_P_HI;
      end
      ST_P_HI: begin
        mul_a      = {1'b0, raw_q};
        mul_b      = {sens[47], sens[47:24]};
        state_next = ST_P_SUM;
      end
      ST_P_SUM: state_next = ST_P_FIN;
      ST_P_FIN: state_next = ST_DONE;
      ST_DONE: begin
        if (res_ready) state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // Keep the stored compensation terms
  always_ff @(posedge clk) begin
    if (rst) begin
      off  <= '0;
      sens <= '0;
    end else begin
      unique case (state)
        ST_T_MC3: off  <= $signed(off_base);
        ST_T_MDT: sens <= $signed(sens_base);
        ST_T_CF: begin
          off  <= off - $signed(off2f);
          sens <= sens - $signed(sens2f);
        end
        ST_T_CG: begin
          if (y[18]) begin
            off  <= off - $signed(off2g);
            sens <= sens - $signed(sens2g);
          end
        end
        default: ;
      endcase
    end
  end

  // Capture the working values
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          raw_q   <= raw;
          is_pres <= !is_temp;
          t2      <= '0;
        end
      end
      ST_T_DT:  dt   <= $signed({1'b0, raw_q}) - $signed({1'b0, cal.c5, 8'b0});
      ST_T_MC4: x    <= prod[40:23];
      ST_T_MF:  t2   <= prod[48:31];
      ST_T_MG:  f    <= prod[35:0];
      ST_T_CF:  g    <= prod[35:0];
      ST_P_HI:  acc  <= 64'(prod);
      ST_P_SUM: acc  <= acc + (64'(prod) <<< 24);
      ST_P_FIN: pres <= p_diff[46:15];
      default: ;
    endcase
  end

  assign busy      = (state != ST_IDLE);
  assign res_valid = (state == ST_DONE);

  // Present the result of the request in hand
  always_comb begin
    res.is_pressure          = is_pres;
    res.temperature_centideg = is_pres ? 32'sd0 : temp_res;
    res.pressure_pa          = is_pres ? pres : 32'sd0;
  end

endmodule

FILE: rtl/core/baro_temp_pressure_compensation_top.sv
`timescale 1ns / 1ps
// Barometric pressure sensor compensation with second-order temperature
// correction. Raw 24-bit converter words arrive on the input channel; a phase
// counter that wraps after PRESSURE_PER_TEMP+1 requests marks the first word of
// each round as temperature and the rest as pressure. A temperature request
// yields the temperature in centidegrees and refreshes the stored offset and
// sensitivity terms; a pressure request yields pressure in pascals from those
// terms. All arithmetic runs through one registered 25x25 signed multiplier
// under a small sequencer, and in_stall stays high while a request is worked;
// a temperature below 20.00 C takes extra multiplier passes for the second-order
// correction. The result waits in an output register, so a new request is
// taken while an earlier result is stalled. The user must write calibration
// words through the cfg port only while the block is idle; the block itself
// does not enforce it.
module baro_temp_pressure_compensation_top #(
  parameter int PRESSURE_PER_TEMP = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [23:0]        raw_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               is_pressure,
  output logic signed [31:0] temperature_centideg,
  output logic signed [31:0] pressure_pa,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import btpc_pkg::*;

  localparam int PHASE_W = $clog2(PRESSURE_PER_TEMP + 1);

  btpc_cal_t          cal;
  logic [PHASE_W-1:0] phase_count;
  logic               start;
  logic               busy;
  logic               res_valid;
  logic               res_ready;
  btpc_res_t          res;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;
  assign start     = in_valid && !in_stall;
  assign res_ready = !out_valid || !out_stall;

  // Write calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_C1:      cal.c1      <= cfg_data;
        CFG_C2:      cal.c2      <= cfg_data;
        CFG_C3:      cal.c3      <= cfg_data;
        CFG_C4:      cal.c4      <= cfg_data;
        CFG_C5:      cal.c5      <= cfg_data;
        CFG_C6:      cal.c6      <= cfg_data;
        CFG_VARIANT: cal.variant <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Advance the phase on every accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count <= '0;
    end else if (start) begin
      if (phase_count == PHASE_W'(PRESSURE_PER_TEMP)) phase_count <= '0;
      else phase_count <= phase_count + 1'b1;
    end
  end

  btpc_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .raw       (raw_sample),
    .is_temp   (phase_count == '0),
    .cal       (cal),
    .res_ready (res_ready),
    .busy      (busy),
    .res_valid (res_valid),
    .res       (res)
  );

  // Hold the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      is_pressure          <= res.is_pressure;
      temperature_centideg <= res.temperature_centideg;
      pressure_pa          <= res.pressure_pa;
    end
  end

endmodule

FILE: rtl/core/btpc_check.sv
`timescale 1ns / 1ps
module btpc_check (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               is_pressure,
  input logic signed [31:0] temperature_centideg,
  input logic signed [31:0] pressure_pa
);

  // A stalled result stays and holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(is_pressure) &&
      $stable(temperature_centideg) && $stable(pressure_pa))
    else $error("stalled result changed");

  // An accepted request keeps the input side stalled while it is worked
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after request");

  // A temperature result carries no pressure
  a_temp_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_pressure |-> pressure_pa == 32'sd0)
    else $error("temperature result with pressure");

  // A pressure result carries no temperature
  a_pres_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_pressure |-> temperature_centideg == 32'sd0)
    else $error("pressure result with temperature");

endmodule

bind baro_temp_pressure_compensation_top btpc_check u_btpc_check (.*);

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import btpc_pkg::*;

  localparam int PRESSURE_PER_TEMP = 3;
  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam int HALF_PERIOD = 2;
  localparam int RESET_CYCLES = 12;
  localparam int IDLE_PCT = 12;
  localparam int MAX_GAP = 16;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_ROUNDS = 8;
  localparam int ITEMS_PER_ROUND = 150;
  localparam int STEADY_ROUND = 3;

  // Typical factory calibration, used by the register-port and temperature-band tests
  localparam btpc_cal_t NOMINAL_CAL = '{
    c1: 16'd40127, c2: 16'd36924, c3: 16'd23317, c4: 16'd23282,
    c5: 16'd33464, c6: 16'd28312, variant: 1'b0
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [23:0]        raw_sample = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               is_pressure;
  logic signed [31:0] temperature_centideg;
  logic signed [31:0] pressure_pa;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  // Shadow of the calibration words and of the compensation state
  longint      cal_word [0:6] = '{default: 0};
  int unsigned sample_phase = 0;
  longint      offset_acc = 0;
  longint      sens_acc = 0;

  btpc_res_t pending_results[$];
  int        error_count = 0;
  bit        steady = 1'b0;

  always #HALF_PERIOD clk = ~clk;

  baro_temp_pressure_compensation_top #(
    .PRESSURE_PER_TEMP(PRESSURE_PER_TEMP)
  ) u_top (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .raw_sample          (raw_sample),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .is_pressure         (is_pressure),
    .temperature_centideg(temperature_centideg),
    .pressure_pa         (pressure_pa),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  // Compute the result of one raw word and advance the shadow state
  function automatic btpc_res_t compensate_sample(input logic [23:0] raw);
    btpc_res_t res;
    longint    raw_l, dt, temp, off, sens, t2, f, g, off2, sens2, prs;
    res = '0;
    raw_l = longint'({40'd0, raw});
    if (sample_phase == 0) begin
      dt = raw_l - (cal_word[CFG_C5] << 8);
      temp = TEMP_NOMINAL + ((dt * cal_word[CFG_C6]) >>> 23);
      if (cal_word[CFG_VARIANT] == 0) begin
        off  = (cal_word[CFG_C2] << 16) + ((cal_word[CFG_C4] * dt) >>> 7);
        sens = (cal_word[CFG_C1] << 15) + ((cal_word[CFG_C3] * dt) >>> 8);
      end else begin
        off  = (cal_word[CFG_C2] << 17) + ((cal_word[CFG_C4] * dt) >>> 6);
        sens = (cal_word[CFG_C1] << 16) + ((cal_word[CFG_C3] * dt) >>> 7);
      end
      // Second-order correction below 20.00 C, extra term below -15.00 C
      if (temp < TEMP_NOMINAL) begin
        t2 = (dt * dt) >>> 31;
        f = (temp - TEMP_NOMINAL) * (temp - TEMP_NOMINAL);
        g = (temp - TEMP_COLD) * (temp - TEMP_COLD);
        if (cal_word[CFG_VARIANT] == 0) begin
          off2 = (5 * f) >>> 1;
          sens2 = (5 * f) >>> 2;
          if (temp < TEMP_COLD) begin
            off2 = off2 + 7 * g;
            sens2 = sens2 + ((11 * g) >>> 1);
          end
        end else begin
          off2 = (61 * f) >>> 4;
          sens2 = 2 * f;
          if (temp < TEMP_COLD) begin
            off2 = off2 + 15 * g;
            sens2 = sens2 + 8 * g;
          end
        end
        temp = temp - t2;
        off = off - off2;
        sens = sens - sens2;
      end
      offset_acc = off;
      sens_acc = sens;
      res.temperature_centideg = 32'(temp);
    end else begin
      prs = (((raw_l * sens_acc) >>> 21) - offset_acc) >>> 15;
      res.is_pressure = 1'b1;
      res.pressure_pa = 32'(prs);
    end
    if (sample_phase >= PRESSURE_PER_TEMP) sample_phase = 0;
    else sample_phase++;
    return res;
  endfunction

  // Pick a raw word; temperature words cluster around the reference point
  function automatic logic [23:0] pick_raw();
    int span, offs, val;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3, 4: begin
        if (sample_phase != 0) return 24'($urandom);
        span = 256 << (4 * $urandom_range(0, 3));
        offs = int'($urandom_range(0, 2 * span)) - span;
        val = int'(cal_word[CFG_C5]) * 256 + offs;
        if (val < 0) val = 0;
        if (val > 24'hFFFFFF) val = 24'hFFFFFF;
        return 24'(val);
      end
      default: return 24'($urandom);
    endcase
  endfunction

  // Send one raw word, with an optional idle gap ahead of it
  task automatic send_raw(input logic [23:0] raw);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(0, 99) < IDLE_PCT) gap = $urandom_range(1, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    raw_sample <= raw;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(compensate_sample(raw));
  endtask

  // Send one temperature word and the pressure words of its round
  task automatic send_round(input logic [23:0] temp_raw, input logic [23:0] p0,
                            input logic [23:0] p1, input logic [23:0] p2);
    send_raw(temp_raw);
    send_raw(p0);
    send_raw(p1);
    send_raw(p2);
  endtask

  // Drop valid and wait until every result is in and the block is quiet
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one calibration register; valid stays up for a following write
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_VARIANT) cal_word[idx] = longint'(data[0]);
    else if (idx != CFG_UNUSED) cal_word[idx] = longint'({48'd0, data});
  endtask

  task automatic program_cal(input btpc_cal_t cal, input logic [14:0] variant_pad);
    write_reg(CFG_C1, cal.c1);
    write_reg(CFG_C2, cal.c2);
    write_reg(CFG_C3, cal.c3);
    write_reg(CFG_C4, cal.c4);
    write_reg(CFG_C5, cal.c5);
    write_reg(CFG_C6, cal.c6);
    write_reg(CFG_VARIANT, {variant_pad, cal.variant});
    cfg_valid <= 1'b0;
  endtask

  // Reset calibration: terms stay zero, so every pressure reads zero
  task automatic test_reset_state();
    send_round(24'h000000, 24'h000000, 24'hFFFFFF, 24'h5A5A5A);
    wait_idle();
  endtask

  // Unused index is ignored and only bit 0 of the variant word counts
  task automatic test_register_port();
    write_reg(CFG_UNUSED, 16'hFFFF);
    program_cal(NOMINAL_CAL, 15'h7FFF);
    send_round(24'd8566784, 24'h000000, 24'hFFFFFF, 24'd9085466);
    wait_idle();
  endtask

  // Just below nominal, very cold, and mildly cold in the other variant
  task automatic test_temperature_bands();
    btpc_cal_t cal;
    send_round(24'd8566783, 24'd9085466, 24'hFFFFFF, 24'h000001);
    send_round(24'h000000, 24'hFFFFFF, 24'd4000000, 24'h800000);
    wait_idle();
    cal = NOMINAL_CAL;
    cal.variant = 1'b1;
    program_cal(cal, 15'h0000);
    send_round(24'd8066784, 24'd9085466, 24'hFFFFFF, 24'h000000);
    wait_idle();
  endtask

  // All calibration words at their maximum, coldest possible reading
  task automatic test_extreme_cal();
    program_cal('1, 15'h5555);
    send_round(24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF);
    wait_idle();
  endtask

  // Random words over several calibration settings, one round without idling
  task automatic test_random_rounds();
    btpc_cal_t cal;
    for (int r = 0; r < RANDOM_ROUNDS; r++) begin
      if (r == 0) begin
        cal = '1;
        cal.variant = 1'b0;
      end else if (r == 1) begin
        cal = '0;
        cal.variant = 1'b1;
      end else begin
        cal.c1 = 16'($urandom);
        cal.c2 = 16'($urandom);
        cal.c3 = 16'($urandom);
        cal.c4 = 16'($urandom);
        cal.c5 = 16'($urandom);
        cal.c6 = 16'($urandom);
        cal.variant = 1'($urandom_range(0, 1));
      end
      program_cal(cal, 15'($urandom));
      steady = (r == STEADY_ROUND);
      repeat (ITEMS_PER_ROUND) send_raw(pick_raw());
      wait_idle();
    end
    steady = 1'b0;
  endtask

  // Stall the result side at random and check each accepted result
  always @(posedge clk) begin
    btpc_res_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: is_pressure %0b temperature_centideg %0d pressure_pa %0d",
                 is_pressure, temperature_centideg, pressure_pa);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (is_pressure !== want.is_pressure) begin
            $error("is_pressure: expected %0b, actual %0b", want.is_pressure, is_pressure);
            error_count++;
          end
          if (temperature_centideg !== want.temperature_centideg) begin
            $error("temperature_centideg: expected %0d, actual %0d",
                   want.temperature_centideg, temperature_centideg);
            error_count++;
          end
          if (pressure_pa !== want.pressure_pa) begin
            $error("pressure_pa: expected %0d, actual %0d", want.pressure_pa, pressure_pa);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_register_port();
    test_temperature_bands();
    test_extreme_cal();
    test_random_rounds();
    if (error_count == 0) begin
      $display("** baro_temp_pressure_compensation_top: PASSED **");
    end else begin
      $display("** baro_temp_pressure_compensation_top: FAILED **");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #2_000_000;
    $display("** baro_temp_pressure_compensation_top: FAILED **");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/btpc_pkg.sv
rtl/core/btpc_mul.sv
rtl/core/btpc_engine.sv
rtl/core/baro_temp_pressure_compensation_top.sv
rtl/core/btpc_check.sv
dv/tb_top.sv
